// ===== sv/bsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types and constants for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

    localparam int INDEX_BITS     = 16;
    localparam int VALUE_BITS     = 32;
    localparam int CAP_BITS       = 5;
    localparam int COUNT_OUT_BITS = 5;

    // -1.0 in signed Q16.16
    localparam logic [VALUE_BITS-1:0] NEG_ONE_Q16 = 32'hFFFF_0000;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        idx;
        logic signed [VALUE_BITS-1:0] val;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_NEW   = 2'd1,
        OP_LEFT  = 2'd2,
        OP_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic     occupied;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// ===== sv/bsq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_cell
// One slot of the sorted row: holds an entry, compares it with the entry
// offered for insertion and loads new, left or right data on command.
// ----------------------------------------------------------------------------
module bsq_cell
    import bsq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       ins_here
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   goes_before;

    // new entry sorts ahead: smaller value, or equal value and index <= held
    assign goes_before = ($signed(new_entry.val) < $signed(entry_reg.val)) ||
                         ((new_entry.val == entry_reg.val) &&
                          (new_entry.idx <= entry_reg.idx));

    // empty slots always accept
    assign ins_here = !ctrl.occupied || goes_before;

    always_comb
    begin
        unique case (ctrl.op)
            OP_HOLD:  entry_next = entry_reg;
            OP_NEW:   entry_next = new_entry;
            OP_LEFT:  entry_next = left_entry;
            OP_RIGHT: entry_next = right_entry;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/bounded_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue
// Keeps the smallest (index, value) entries in ascending order in a row of
// cells; enqueue, dequeue-minimum and clear, one result item per command.
// ----------------------------------------------------------------------------
//
//  channel    handshake              payload
//  --------   --------------------   ---------------------------------------
//  request    req_valid / req_stall  command, item_index, item_value
//  result     res_valid / res_stall  status, entry_count, min/max index and
//                                    value, is_empty, is_full
//  config     capacity_we            capacity_wdata
//
//  Order: the accept edge updates every cell of the row at once (all cells
//  compare against the incoming entry in parallel); once the result register
//  is free, min/max are read from the row into the result register.
//  Reset: entry count cleared, capacity 16. Cell contents are not reset;
//  only the first entry_count cells are ever read.
//  Stalls: the result register holds a finished item while the next request
//  item is accepted; a further item waits until that result is taken.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue
    import bsq_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         capacity_we,
    input  logic [CAP_BITS-1:0]          capacity_wdata,

    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [1:0]                   command,
    input  logic signed [INDEX_BITS:0]   item_index,
    input  logic signed [VALUE_BITS-1:0] item_value,

    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [1:0]                   status,
    output logic [COUNT_OUT_BITS-1:0]    entry_count,
    output logic [INDEX_BITS-1:0]        min_index,
    output logic signed [VALUE_BITS-1:0] min_value,
    output logic [INDEX_BITS-1:0]        max_index,
    output logic signed [VALUE_BITS-1:0] max_value,
    output logic                         is_empty,
    output logic                         is_full
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // ---------------- configuration ----------------
    logic [CAP_BITS-1:0] capacity_reg;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    eff_ext;
    logic [CNT_W-1:0]    eff_cap;

    // capacity 0 acts as 1, above the row length acts as the row length
    assign cap_ext = CMP_W'(capacity_reg);
    assign eff_ext = (capacity_reg == '0) ? CMP_W'(1) :
                     (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
    assign eff_cap = CNT_W'(eff_ext);

    // ---------------- control state ----------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pending_reg;
    logic             pending_next;
    status_t          stat_pend_reg;
    status_t          stat_pend_next;
    logic             res_valid_reg;
    logic             res_valid_next;

    logic accept;
    logic res_free;
    logic res_load;

    assign req_stall = pending_reg;
    assign accept    = req_valid && !req_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_load  = pending_reg && res_free;

    // ---------------- cell row ----------------
    entry_t                 cell_entry [MAX_ENTRIES];
    cell_ctrl_t             cell_ctrl  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] ins_vec;
    logic [MAX_ENTRIES-1:0] occ_vec;
    logic [MAX_ENTRIES-1:0] new_vec;
    entry_t                 new_entry;

    assign new_entry.idx = item_index[INDEX_BITS-1:0];
    assign new_entry.val = item_value;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;

            if (g == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid_l
                assign left_e = cell_entry[g-1];
            end

            if (g == MAX_ENTRIES - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid_r
                assign right_e = cell_entry[g+1];
            end

            bsq_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[g]),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .ins_here    (ins_vec[g])
            );
        end
    endgenerate

    // ---------------- command decode ----------------
    logic item_ok;
    logic any_before;
    logic over_cap;
    cmd_t cmd;

    assign cmd        = cmd_t'(command);
    assign item_ok    = !item_index[INDEX_BITS] && (item_value != NEG_ONE_Q16);
    assign any_before = |(ins_vec & occ_vec);
    // one more entry would pass the capacity: the largest goes
    assign over_cap   = (count_reg >= eff_cap);

    always_comb
    begin
        count_next     = count_reg;
        stat_pend_next = stat_pend_reg;
        new_vec        = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            occ_vec[i]           = (CNT_W'(i) < count_reg);
            cell_ctrl[i].occupied = occ_vec[i];
            cell_ctrl[i].op       = OP_HOLD;
        end

        if (accept)
        begin
            unique case (cmd)
                CMD_ENQUEUE:
                begin
                    if (!item_ok)
                    begin
                        stat_pend_next = STAT_INVALID;
                    end
                    else
                    begin
                        // insertion point is the first flagged cell; all after it shift
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            if (i > 0 && ins_vec[i-1])
                            begin
                                cell_ctrl[i].op = OP_LEFT;
                            end
                            else if (ins_vec[i])
                            begin
                                cell_ctrl[i].op = OP_NEW;
                                new_vec[i]      = 1'b1;
                            end
                        end
                        if (over_cap)
                        begin
                            stat_pend_next = any_before ? STAT_OK : STAT_FULL;
                        end
                        else
                        begin
                            count_next     = count_reg + CNT_W'(1);
                            stat_pend_next = STAT_OK;
                        end
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (count_reg == '0)
                    begin
                        stat_pend_next = STAT_EMPTY;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_ENTRIES - 1; i++)
                        begin
                            cell_ctrl[i].op = OP_RIGHT;
                        end
                        count_next     = count_reg - CNT_W'(1);
                        stat_pend_next = STAT_OK;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next     = '0;
                    stat_pend_next = STAT_OK;
                end
                default:
                begin
                    stat_pend_next = STAT_INVALID;
                end
            endcase
        end
    end

    // ---------------- handshake state ----------------
    always_comb
    begin
        pending_next   = pending_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            pending_next   = 1'b0;
            res_valid_next = 1'b1;
        end
        if (accept)
        begin
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_BITS'(16);
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            stat_pend_reg <= STAT_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            stat_pend_reg <= stat_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------- result register ----------------
    logic [IDX_W-1:0]            last_sel;
    entry_t                      max_e;
    logic                        row_empty;

    logic [1:0]                  status_reg;
    logic [COUNT_OUT_BITS-1:0]   entry_count_reg;
    logic [INDEX_BITS-1:0]       min_index_reg;
    logic signed [VALUE_BITS-1:0] min_value_reg;
    logic [INDEX_BITS-1:0]       max_index_reg;
    logic signed [VALUE_BITS-1:0] max_value_reg;
    logic                        is_empty_reg;
    logic                        is_full_reg;

    assign row_empty = (count_reg == '0);
    assign last_sel  = IDX_W'(count_reg - CNT_W'(1));
    assign max_e     = cell_entry[last_sel];

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg      <= stat_pend_reg;
            entry_count_reg <= COUNT_OUT_BITS'(count_reg);
            min_index_reg   <= row_empty ? '0 : cell_entry[0].idx;
            min_value_reg   <= row_empty ? '0 : cell_entry[0].val;
            max_index_reg   <= row_empty ? '0 : max_e.idx;
            max_value_reg   <= row_empty ? '0 : max_e.val;
            is_empty_reg    <= row_empty;
            is_full_reg     <= (count_reg == eff_cap);
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign min_index   = min_index_reg;
    assign min_value   = min_value_reg;
    assign max_index   = max_index_reg;
    assign max_value   = max_value_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond row length");

    a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pending_reg)
        else $error("accepted item not pending for result");

    a_single_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(new_vec) <= 1)
        else $error("new entry written into more than one cell");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> (count_reg == $past(count_reg)))
        else $error("entry count changed without a command");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (is_empty_reg == (entry_count_reg == '0)))
        else $error("empty flag disagrees with entry count");

endmodule

// ===== bench/bsq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_result_checker
// Watches the capacity, request and result ports of the sorted queue. Keeps
// its own sorted copy of the held entries, works out the result item of each
// accepted request and compares it field by field with the result item that
// the queue hands out, in order.
// ----------------------------------------------------------------------------
module bsq_result_checker
    import bsq_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         capacity_we,
    input  logic [CAP_BITS-1:0]          capacity_wdata,

    input  logic                         req_valid,
    input  logic                         req_stall,
    input  logic [1:0]                   command,
    input  logic signed [INDEX_BITS:0]   item_index,
    input  logic signed [VALUE_BITS-1:0] item_value,

    input  logic                         res_valid,
    input  logic                         res_stall,
    input  logic [1:0]                   status,
    input  logic [COUNT_OUT_BITS-1:0]    entry_count,
    input  logic [INDEX_BITS-1:0]        min_index,
    input  logic signed [VALUE_BITS-1:0] min_value,
    input  logic [INDEX_BITS-1:0]        max_index,
    input  logic signed [VALUE_BITS-1:0] max_value,
    input  logic                         is_empty,
    input  logic                         is_full,

    output int                           snapshots_waiting,
    output int                           mismatches
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]                   status;
        logic [COUNT_OUT_BITS-1:0]    count;
        logic [INDEX_BITS-1:0]        min_idx;
        logic signed [VALUE_BITS-1:0] min_val;
        logic [INDEX_BITS-1:0]        max_idx;
        logic signed [VALUE_BITS-1:0] max_val;
        logic                         empty;
        logic                         full;
    } queue_snapshot_t;

    // one spare slot holds an entry that is evicted right away
    entry_t              held_entries [0:MAX_ENTRIES];
    int unsigned         held_n;
    logic [CAP_BITS-1:0] capacity_setting;
    queue_snapshot_t     awaited_results [$];
    queue_snapshot_t     want;

    function automatic int unsigned capacity_limit();
        if (capacity_setting == '0)
            return 1;
        if (capacity_setting > MAX_ENTRIES)
            return MAX_ENTRIES;
        return 32'(capacity_setting);
    endfunction

    // Updates the held entries for one command and returns the result item.
    function automatic queue_snapshot_t apply_command(
        input logic [1:0]                   cmd,
        input logic signed [INDEX_BITS:0]   idx,
        input logic signed [VALUE_BITS-1:0] val
    );
        queue_snapshot_t       snap;
        int unsigned           pos;
        int unsigned           k;
        logic [INDEX_BITS-1:0] new_idx;

        new_idx = idx[INDEX_BITS-1:0];
        snap = '0;
        snap.status = STAT_OK;
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (idx[INDEX_BITS] || val == NEG_ONE_Q16)
                begin
                    snap.status = STAT_INVALID;
                end
                else
                begin
                    // new entry goes ahead of equal value with index >= its own
                    pos = 0;
                    while (pos < held_n &&
                           (val > $signed(held_entries[pos].val) ||
                            (val == $signed(held_entries[pos].val) &&
                             new_idx > held_entries[pos].idx)))
                        pos++;
                    for (k = held_n; k > pos; k--)
                        held_entries[k] = held_entries[k - 1];
                    held_entries[pos].idx = new_idx;
                    held_entries[pos].val = val;
                    held_n++;
                    if (held_n > capacity_limit())
                    begin
                        held_n--;
                        if (pos == held_n)
                            snap.status = STAT_FULL;
                    end
                end
            end
            CMD_DEQUEUE:
            begin
                if (held_n == 0)
                begin
                    snap.status = STAT_EMPTY;
                end
                else
                begin
                    for (k = 1; k < held_n; k++)
                        held_entries[k - 1] = held_entries[k];
                    held_n--;
                end
            end
            CMD_CLEAR:
            begin
                held_n = 0;
            end
            default:
            begin
                snap.status = STAT_INVALID;
            end
        endcase

        snap.count = COUNT_OUT_BITS'(held_n);
        snap.empty = (held_n == 0);
        snap.full  = (held_n == capacity_limit());
        if (held_n != 0)
        begin
            snap.min_idx = held_entries[0].idx;
            snap.min_val = held_entries[0].val;
            snap.max_idx = held_entries[held_n - 1].idx;
            snap.max_val = held_entries[held_n - 1].val;
        end
        return snap;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n = 0;
            capacity_setting = 5'd16;
            awaited_results.delete();
            mismatches = 0;
            snapshots_waiting <= 0;
        end
        else
        begin
            if (capacity_we)
                capacity_setting = capacity_wdata;
            if (req_valid && !req_stall)
                awaited_results.push_back(apply_command(command, item_index, item_value));
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result item with nothing awaited, status %0d",
                                              status));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(status), 32'(want.status));
                    compare_field("entry_count", 32'(entry_count), 32'(want.count));
                    compare_field("min_index", 32'(min_index), 32'(want.min_idx));
                    compare_field("min_value", min_value, want.min_val);
                    compare_field("max_index", 32'(max_index), 32'(want.max_idx));
                    compare_field("max_value", max_value, want.max_val);
                    compare_field("is_empty", 32'(is_empty), 32'(want.empty));
                    compare_field("is_full", 32'(is_full), 32'(want.full));
                end
            end
            snapshots_waiting <= awaited_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the sorted priority queue with a short directed list and then with
// phases of random commands, one capacity setting per phase, with random gaps
// on the request side and random stalls on the result side. The checker
// beside the queue predicts and compares; this module makes the stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bsq_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 138;

    // command code the block does not define; it must answer with invalid
    localparam logic [1:0]                 CMD_UNUSED = 2'd3;
    localparam logic signed [INDEX_BITS:0] INDEX_NONE = '1;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         capacity_we    = 1'b0;
    logic [CAP_BITS-1:0]          capacity_wdata = '0;
    logic                         req_valid      = 1'b0;
    logic [1:0]                   command        = CMD_ENQUEUE;
    logic signed [INDEX_BITS:0]   item_index     = '0;
    logic signed [VALUE_BITS-1:0] item_value     = '0;
    logic                         res_stall      = 1'b0;

    logic                         req_stall;
    logic                         res_valid;
    logic [1:0]                   status;
    logic [COUNT_OUT_BITS-1:0]    entry_count;
    logic [INDEX_BITS-1:0]        min_index;
    logic signed [VALUE_BITS-1:0] min_value;
    logic [INDEX_BITS-1:0]        max_index;
    logic signed [VALUE_BITS-1:0] max_value;
    logic                         is_empty;
    logic                         is_full;

    int snapshots_waiting;
    int mismatches;

    int unsigned items_sent      = 0;
    int unsigned capacity_writes = 0;
    bit          calm_sender     = 1'b0;   // stretch with no request gaps
    int unsigned stall_left      = 0;

    // Capacities of the first random phases: the extremes, the out-of-range
    // codes (0 acts as 1, above 16 acts as 16) and a few in between. The last
    // phases pick one at random.
    logic [CAP_BITS-1:0] capacity_plan [0:9] = '{5'd16, 5'd31, 5'd1, 5'd3, 5'd0,
                                                 5'd16, 5'd2, 5'd17, 5'd8, 5'd5};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bounded_sorted_priority_queue #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .command        (command),
        .item_index     (item_index),
        .item_value     (item_value),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .status         (status),
        .entry_count    (entry_count),
        .min_index      (min_index),
        .min_value      (min_value),
        .max_index      (max_index),
        .max_value      (max_value),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    bsq_result_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) result_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .capacity_we       (capacity_we),
        .capacity_wdata    (capacity_wdata),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .command           (command),
        .item_index        (item_index),
        .item_value        (item_value),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .status            (status),
        .entry_count       (entry_count),
        .min_index         (min_index),
        .min_value         (min_value),
        .max_index         (max_index),
        .max_value         (max_value),
        .is_empty          (is_empty),
        .is_full           (is_full),
        .snapshots_waiting (snapshots_waiting),
        .mismatches        (mismatches)
    );

    // ------------------------------------------------------------------
    // Result side: the stall pattern runs on its own. Mostly short ready
    // and stall runs, sometimes a long stall, and now and then a long
    // stretch with no stall at all.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_pattern
        int unsigned roll;
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                res_stall  <= 1'b0;
                stall_left <= $urandom_range(40, 150);
            end
            else if (roll < 55)
            begin
                res_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end
            else if (roll < 88)
            begin
                res_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (roll < 97)
            begin
                res_stall  <= 1'b1;
                stall_left <= $urandom_range(3, 12);
            end
            else
            begin
                res_stall  <= 1'b1;
                stall_left <= $urandom_range(20, 40);
            end
        end
    end

    // Idle cycles before the next request item.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_sender || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Values lean toward a small pool so that ties are common; the rest are
    // the signed extremes, the neighbors of -1.0, -1.0 itself and raw words.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned                  roll;
        logic signed [VALUE_BITS-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            v = $urandom_range(0, 7) << 15;
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        else if (roll < 55)
        begin
            case ($urandom_range(0, 5))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                3:       v = 32'hFFFF_FFFF;
                4:       v = 32'hFFFF_0001;
                default: v = 32'hFFFE_FFFF;
            endcase
        end
        else if (roll < 58)
        begin
            v = NEG_ONE_Q16;
        end
        else
        begin
            v = $urandom();
        end
        return v;
    endfunction

    // Indexes: mostly small (ties on value then sort by index), the ends of
    // the range, raw 16-bit values and a few negative ones.
    function automatic logic signed [INDEX_BITS:0] pick_index();
        int unsigned                roll;
        logic signed [INDEX_BITS:0] ix;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            ix = 17'($urandom_range(0, 7));
        else if (roll < 54)
            ix = 17'h0FFFF;
        else if (roll < 58)
            ix = 17'h00000;
        else if (roll < 95)
            ix = 17'($urandom_range(0, 65535));
        else if (roll < 97)
            ix = INDEX_NONE;
        else
            ix = {1'b1, 16'($urandom())};
        return ix;
    endfunction

    // Called at a rising edge. Waits out a random gap, presents the item and
    // returns at the edge where it is accepted. A back-to-back item keeps
    // valid high with a single assignment.
    task automatic send_req(input logic [1:0] cmd, input logic signed [INDEX_BITS:0] idx,
                            input logic signed [VALUE_BITS-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        command    <= cmd;
        item_index <= idx;
        item_value <= val;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
    endtask

    // Lets every outstanding result come back, then a few spare cycles for
    // the pipeline.
    task automatic drain_queue();
        req_valid <= 1'b0;
        @(posedge clk);
        while (snapshots_waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Capacity changes only while the block is idle.
    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        drain_queue();
        capacity_we    <= 1'b1;
        capacity_wdata <= cap;
        @(posedge clk);
        capacity_we    <= 1'b0;
        capacity_writes++;
    endtask

    initial
    begin
        int unsigned roll;
        int unsigned phase;
        int unsigned n;
        int unsigned enq_share;
        int unsigned deq_top;
        int unsigned clear_top;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --------------------------------------------------------------
        // Directed part
        // --------------------------------------------------------------
        // nothing to take from an empty queue; unused command code
        send_req(CMD_DEQUEUE, 17'd0, 32'd0);
        send_req(CMD_UNUSED, 17'd3, 32'h0001_0000);
        // rejected entries: index -1, value -1.0, another negative index
        send_req(CMD_ENQUEUE, INDEX_NONE, 32'd0);
        send_req(CMD_ENQUEUE, 17'd5, NEG_ONE_Q16);
        send_req(CMD_ENQUEUE, 17'h1FFFE, 32'h0001_0000);
        // first entry into an empty queue, then the extremes and the ties:
        // equal value with larger index goes behind, equal index goes ahead
        send_req(CMD_ENQUEUE, 17'd0, 32'h7FFF_FFFF);
        send_req(CMD_ENQUEUE, 17'h0FFFF, 32'h8000_0000);
        send_req(CMD_ENQUEUE, 17'd3, 32'h7FFF_FFFF);
        send_req(CMD_ENQUEUE, 17'd0, 32'h7FFF_FFFF);
        // just above -1.0 is a legal value
        send_req(CMD_ENQUEUE, 17'd7, 32'hFFFF_0001);
        send_req(CMD_DEQUEUE, 17'd0, 32'd0);
        send_req(CMD_CLEAR, 17'd0, 32'd0);

        // capacity 1: a larger entry is dropped as full, a smaller one
        // pushes the held entry out
        set_capacity(5'd1);
        send_req(CMD_ENQUEUE, 17'd4, 32'h000A_0000);
        send_req(CMD_ENQUEUE, 17'd9, 32'h0014_0000);
        send_req(CMD_ENQUEUE, 17'd2, 32'h000A_0000);

        // capacity code 0 behaves as 1; an identical entry lands in front
        set_capacity(5'd0);
        send_req(CMD_ENQUEUE, 17'd1, 32'd0);
        send_req(CMD_ENQUEUE, 17'd1, 32'd0);

        // capacity dropped below the count: no eviction until the next
        // enqueue, and that one evicts only one entry
        set_capacity(5'd16);
        send_req(CMD_CLEAR, 17'd0, 32'd0);
        send_req(CMD_ENQUEUE, 17'd8, 32'h0003_0000);
        send_req(CMD_ENQUEUE, 17'd6, 32'hFFFE_0000);
        send_req(CMD_ENQUEUE, 17'd2, 32'h0001_8000);
        send_req(CMD_ENQUEUE, 17'd9, 32'h0000_4000);
        set_capacity(5'd2);
        send_req(CMD_ENQUEUE, 17'd6, 32'h0000_0005);
        send_req(CMD_DEQUEUE, 17'd0, 32'd0);
        send_req(CMD_DEQUEUE, 17'd0, 32'd0);

        // --------------------------------------------------------------
        // Random phases. Even phases lean toward filling the queue so that
        // eviction and full status come up; odd phases drain more.
        // --------------------------------------------------------------
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 10)
                set_capacity(capacity_plan[phase]);
            else
                set_capacity(5'($urandom_range(0, 31)));
            enq_share = (phase % 2 == 0) ? 68 : 45;
            deq_top   = (phase % 2 == 0) ? 95 : 92;
            clear_top = (phase % 2 == 0) ? 96 : 95;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 46 == 0)
                    calm_sender = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                // dequeue and clear carry random payload, which is ignored
                if (roll < enq_share)
                    send_req(CMD_ENQUEUE, pick_index(), pick_value());
                else if (roll < deq_top)
                    send_req(CMD_DEQUEUE, 17'($urandom()), $urandom());
                else if (roll < clear_top)
                    send_req(CMD_CLEAR, 17'($urandom()), $urandom());
                else if (roll < 98)
                    send_req(CMD_UNUSED, 17'($urandom()), $urandom());
                else
                    send_req(CMD_ENQUEUE, INDEX_NONE, pick_value());
            end
        end

        drain_queue();
        repeat (10) @(posedge clk);

        $display("Sent %0d request items (enqueue, dequeue, clear, unused code) over %0d",
                 items_sent, capacity_writes);
        $display("capacity settings, with random request gaps and result stalls.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #20_000_000;
        $display("Timeout: results still outstanding: %0d", snapshots_waiting);
        $display("Mismatches found");
        $finish;
    end

endmodule
